// ----- rtl/rendezvous_ipc_engine_core_defines.svh -----
// assertion macros used by the checker file of the rendezvous ipc engine
// depends on nothing; take it in by `include with the bare file name
`ifndef RENDEZVOUS_IPC_ENGINE_CORE_DEFINES_SVH
`define RENDEZVOUS_IPC_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define RIE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rie_pkg.sv -----
// codes, command and status types of the rendezvous ipc engine
// used by the controller, the datapath and the checker; depends on nothing
package rie_pkg;

   // request function
   localparam logic [1:0] FUNC_SEND   = 2'd0;
   localparam logic [1:0] FUNC_RECV   = 2'd1;
   localparam logic [1:0] FUNC_NOTICE = 2'd2;
   localparam logic [1:0] FUNC_BAD    = 2'd3;

   // peer kind
   localparam logic [1:0] KIND_SPEC = 2'd0;
   localparam logic [1:0] KIND_ANY  = 2'd1;
   localparam logic [1:0] KIND_INTR = 2'd2;
   localparam logic [1:0] KIND_BAD  = 2'd3;

   // result status
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DEADLOCK = 2'd1;
   localparam logic [1:0] ST_INVALID  = 2'd2;

   // copy kind
   localparam logic [1:0] CP_NONE   = 2'd0;
   localparam logic [1:0] CP_SENDER = 2'd1;
   localparam logic [1:0] CP_INTR   = 2'd2;

   // table read select
   localparam logic [1:0] RD_ME  = 2'd0;
   localparam logic [1:0] RD_CUR = 2'd1;
   localparam logic [1:0] RD_S   = 2'd2;

   // walk pointer operation
   localparam logic [2:0] CUR_HOLD    = 3'd0;
   localparam logic [2:0] CUR_PEER    = 3'd1;
   localparam logic [2:0] CUR_S_HEAD  = 3'd2;
   localparam logic [2:0] CUR_ME_HEAD = 3'd3;
   localparam logic [2:0] CUR_TGT     = 3'd4;
   localparam logic [2:0] CUR_QNEXT   = 3'd5;

   // partner index operation
   localparam logic [1:0] S_HOLD    = 2'd0;
   localparam logic [1:0] S_PEER    = 2'd1;
   localparam logic [1:0] S_ME_HEAD = 2'd2;

   // table write operation
   localparam logic [3:0] WR_NONE        = 4'd0;
   localparam logic [3:0] WR_RCV_REL_S   = 4'd1;
   localparam logic [3:0] WR_ME_SEND_BLK = 4'd2;
   localparam logic [3:0] WR_HEAD_S      = 4'd3;
   localparam logic [3:0] WR_TAIL        = 4'd4;
   localparam logic [3:0] WR_ME_INT_CLR  = 4'd5;
   localparam logic [3:0] WR_ME_HEAD     = 4'd6;
   localparam logic [3:0] WR_PREV_NEXT   = 4'd7;
   localparam logic [3:0] WR_S_REL_SND   = 4'd8;
   localparam logic [3:0] WR_ME_RCV_BLK  = 4'd9;
   localparam logic [3:0] WR_ME_NTC_WAKE = 4'd10;
   localparam logic [3:0] WR_ME_PEND_SET = 4'd11;

   // result operation
   localparam logic [3:0] RES_NONE       = 4'd0;
   localparam logic [3:0] RES_BAD        = 4'd1;
   localparam logic [3:0] RES_DL         = 4'd2;
   localparam logic [3:0] RES_SEND_WAKE  = 4'd3;
   localparam logic [3:0] RES_SEND_BLK   = 4'd4;
   localparam logic [3:0] RES_INT_TAKE   = 4'd5;
   localparam logic [3:0] RES_RECV_WAKE  = 4'd6;
   localparam logic [3:0] RES_RECV_BLK   = 4'd7;
   localparam logic [3:0] RES_NTC_WAKE   = 4'd8;
   localparam logic [3:0] RES_NTC_PEND   = 4'd9;

   typedef struct packed {
      logic       ld_req;
      logic [1:0] rd_sel;
      logic       ld_me;
      logic       ld_s;
      logic [2:0] cur_op;
      logic [1:0] s_op;
      logic [3:0] wr_op;
      logic [3:0] res_op;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic [1:0] kind;
      logic       me_bad;
      logic       dl_hit;
      logic       dl_stop;
      logic       wake_ok;
      logic       head_empty;
      logic       tail_here;
      logic       walk_last;
      logic       pend_take;
      logic       me_head_empty;
      logic       s_ok;
      logic       ul_miss;
      logic       ul_hit;
      logic       prev_none;
      logic       notice_wake;
      logic       first_step;
      logic       out_free;
   } status_type;

endpackage

// ----- rtl/rie_datapath.sv -----
// rendezvous table, walk registers, result and output register
// depends on rie_pkg; driven by rie_controller through cmd_type
module rie_datapath #(
   parameter int NUM_PROCS = 16,
   parameter int ADDR_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rie_pkg::cmd_type           cmd,
   output rie_pkg::status_type        stat,
   input  logic [((8+ADDR_BITS+7)/8)*8-1:0]  req_tdata,
   input  logic [3:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [((12+2*ADDR_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic [5:0]                 rsp_tuser
);
   localparam int IW = $clog2(NUM_PROCS);
   localparam int PW = $clog2(NUM_PROCS + 3);
   localparam int SW = $clog2(NUM_PROCS + 1);
   localparam int RSP_DW = ((12+2*ADDR_BITS+7)/8)*8;
   localparam int RSP_USED = 12 + 2*ADDR_BITS;
   localparam logic [PW-1:0] CODE_NONE = PW'(NUM_PROCS);
   localparam logic [PW-1:0] CODE_ANY  = PW'(NUM_PROCS + 1);
   localparam logic [PW-1:0] CODE_INTR = PW'(NUM_PROCS + 2);
   localparam logic [6:0] NP7 = 7'(NUM_PROCS);

   typedef struct packed {
      logic                 sending;
      logic                 receiving;
      logic                 pend;
      logic [PW-1:0]        target;
      logic [PW-1:0]        src;
      logic [PW-1:0]        head;
      logic [PW-1:0]        q_next;
      logic [ADDR_BITS-1:0] buffer;
   } rec_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 blocked;
      logic                 woken_valid;
      logic [3:0]           woken_pid;
      logic [1:0]           copy_kind;
      logic [3:0]           dst_pid;
      logic [ADDR_BITS-1:0] dst_addr;
      logic [3:0]           src_pid;
      logic [ADDR_BITS-1:0] src_addr;
   } res_type;

   localparam rec_type RST_REC = '{sending: 1'b0, receiving: 1'b0, pend: 1'b0,
                                   target: CODE_NONE, src: CODE_NONE,
                                   head: CODE_NONE, q_next: CODE_NONE,
                                   buffer: '0};

   // request
   logic [1:0]           func_ff, kind_ff;
   logic [3:0]           me_ff, peer_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   // table
   rec_type              mem [NUM_PROCS];
   logic [NUM_PROCS-1:0] valid_ff;
   rec_type              rd_raw_ff;
   logic                 rd_vld_ff;
   rec_type              rd_q;
   logic [IW-1:0]        rd_idx, wr_idx;
   logic                 wr_en;
   rec_type              wr_rec;

   // walk state
   rec_type              me_rec_ff, s_rec_ff, prev_rec_ff;
   logic [PW-1:0]        cur_ff, s_ff, prev_ff;
   logic [SW-1:0]        steps_ff;

   res_type              res_ff, res_in, out_ff;
   logic                 out_valid_ff;

   logic [PW-1:0]        me_p, peer_p;
   logic                 me_ok, peer_ok;

   assign me_p    = PW'(me_ff);
   assign peer_p  = PW'(peer_ff);
   assign me_ok   = {3'b000, me_ff} < NP7;
   assign peer_ok = {3'b000, peer_ff} < NP7;
   assign rd_q    = rd_vld_ff ? rd_raw_ff : RST_REC;

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         func_ff <= req_tuser[1:0];
         kind_ff <= req_tuser[3:2];
         me_ff   <= req_tdata[3:0];
         peer_ff <= req_tdata[7:4];
         addr_ff <= req_tdata[8+ADDR_BITS-1:8];
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         rie_pkg::RD_ME: rd_idx = IW'(me_ff);
         rie_pkg::RD_S:  rd_idx = IW'(s_ff);
         default:        rd_idx = IW'(cur_ff);
      endcase
   end

   always_comb begin
      wr_en  = 1'b1;
      wr_idx = IW'(me_ff);
      wr_rec = me_rec_ff;
      unique case (cmd.wr_op)
         rie_pkg::WR_RCV_REL_S: begin
            wr_idx = IW'(s_ff);
            wr_rec = s_rec_ff;
            wr_rec.receiving = 1'b0;
            wr_rec.src = CODE_NONE;
            wr_rec.buffer = '0;
         end
         rie_pkg::WR_ME_SEND_BLK: begin
            wr_rec.sending = 1'b1;
            wr_rec.target = peer_p;
            wr_rec.buffer = addr_ff;
            wr_rec.q_next = CODE_NONE;
         end
         rie_pkg::WR_HEAD_S: begin
            wr_idx = IW'(s_ff);
            wr_rec = s_rec_ff;
            wr_rec.head = me_p;
         end
         rie_pkg::WR_TAIL: begin
            wr_idx = IW'(cur_ff);
            wr_rec = rd_q;
            wr_rec.q_next = me_p;
         end
         rie_pkg::WR_ME_INT_CLR: wr_rec.pend = 1'b0;
         rie_pkg::WR_ME_HEAD:    wr_rec.head = s_rec_ff.q_next;
         rie_pkg::WR_PREV_NEXT: begin
            wr_idx = IW'(prev_ff);
            wr_rec = prev_rec_ff;
            wr_rec.q_next = s_rec_ff.q_next;
         end
         rie_pkg::WR_S_REL_SND: begin
            wr_idx = IW'(s_ff);
            wr_rec = s_rec_ff;
            wr_rec.sending = 1'b0;
            wr_rec.target = CODE_NONE;
            wr_rec.buffer = '0;
            wr_rec.q_next = CODE_NONE;
         end
         rie_pkg::WR_ME_RCV_BLK: begin
            wr_rec.receiving = 1'b1;
            wr_rec.buffer = addr_ff;
            wr_rec.src = (kind_ff == rie_pkg::KIND_ANY)  ? CODE_ANY :
                         (kind_ff == rie_pkg::KIND_INTR) ? CODE_INTR : peer_p;
         end
         rie_pkg::WR_ME_NTC_WAKE: begin
            wr_rec.receiving = 1'b0;
            wr_rec.src = CODE_NONE;
            wr_rec.buffer = '0;
            wr_rec.pend = 1'b0;
         end
         rie_pkg::WR_ME_PEND_SET: wr_rec.pend = 1'b1;
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_rec;
      end
      rd_raw_ff <= mem[rd_idx];
   end

   // an entry never written reads as the reset record
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= valid_ff[rd_idx];
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_me) begin
         me_rec_ff <= rd_q;
      end
      if (cmd.ld_s) begin
         s_rec_ff <= rd_q;
      end
      unique case (cmd.s_op)
         rie_pkg::S_PEER:    s_ff <= peer_p;
         rie_pkg::S_ME_HEAD: s_ff <= me_rec_ff.head;
         default: ;
      endcase
      unique case (cmd.cur_op)
         rie_pkg::CUR_PEER: begin
            cur_ff <= peer_p;
            prev_ff <= CODE_NONE;
            steps_ff <= '0;
         end
         rie_pkg::CUR_S_HEAD: begin
            cur_ff <= s_rec_ff.head;
            prev_ff <= CODE_NONE;
            steps_ff <= '0;
         end
         rie_pkg::CUR_ME_HEAD: begin
            cur_ff <= me_rec_ff.head;
            prev_ff <= CODE_NONE;
            steps_ff <= '0;
         end
         rie_pkg::CUR_TGT: begin
            cur_ff <= rd_q.target;
            steps_ff <= steps_ff + 1'b1;
         end
         rie_pkg::CUR_QNEXT: begin
            prev_ff <= cur_ff;
            prev_rec_ff <= rd_q;
            cur_ff <= rd_q.q_next;
            steps_ff <= steps_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      res_in = '0;
      unique case (cmd.res_op)
         rie_pkg::RES_BAD: res_in.status = rie_pkg::ST_INVALID;
         rie_pkg::RES_DL:  res_in.status = rie_pkg::ST_DEADLOCK;
         rie_pkg::RES_SEND_WAKE: begin
            res_in.woken_valid = 1'b1;
            res_in.woken_pid = peer_ff;
            res_in.copy_kind = rie_pkg::CP_SENDER;
            res_in.dst_pid = peer_ff;
            res_in.dst_addr = s_rec_ff.buffer;
            res_in.src_pid = me_ff;
            res_in.src_addr = addr_ff;
         end
         rie_pkg::RES_SEND_BLK, rie_pkg::RES_RECV_BLK: res_in.blocked = 1'b1;
         rie_pkg::RES_INT_TAKE: begin
            res_in.copy_kind = rie_pkg::CP_INTR;
            res_in.dst_pid = me_ff;
            res_in.dst_addr = addr_ff;
         end
         rie_pkg::RES_RECV_WAKE: begin
            res_in.woken_valid = 1'b1;
            res_in.woken_pid = 4'(s_ff);
            res_in.copy_kind = rie_pkg::CP_SENDER;
            res_in.dst_pid = me_ff;
            res_in.dst_addr = addr_ff;
            res_in.src_pid = 4'(s_ff);
            res_in.src_addr = s_rec_ff.buffer;
         end
         rie_pkg::RES_NTC_WAKE: begin
            res_in.woken_valid = 1'b1;
            res_in.woken_pid = me_ff;
            res_in.copy_kind = rie_pkg::CP_INTR;
            res_in.dst_pid = me_ff;
            res_in.dst_addr = me_rec_ff.buffer;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_op != rie_pkg::RES_NONE) begin
         res_ff <= res_in;
      end
      if (cmd.push) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_ff.copy_kind, out_ff.woken_valid, out_ff.blocked, out_ff.status};
   assign rsp_tdata  = {{(RSP_DW-RSP_USED){1'b0}}, out_ff.src_addr, out_ff.src_pid,
                        out_ff.dst_addr, out_ff.dst_pid, out_ff.woken_pid};

   always_comb begin
      stat.func = func_ff;
      stat.kind = kind_ff;
      stat.me_bad = (func_ff == rie_pkg::FUNC_BAD) || !me_ok ||
         ((func_ff != rie_pkg::FUNC_NOTICE) &&
          ((kind_ff == rie_pkg::KIND_BAD) ||
           ((kind_ff == rie_pkg::KIND_SPEC) && (!peer_ok || peer_ff == me_ff)) ||
           ((func_ff == rie_pkg::FUNC_SEND) && (kind_ff != rie_pkg::KIND_SPEC)) ||
           me_rec_ff.sending || me_rec_ff.receiving));
      stat.dl_hit = rd_q.sending && (rd_q.target == me_p);
      stat.walk_last = steps_ff == SW'(NUM_PROCS - 1);
      stat.dl_stop = !rd_q.sending || stat.walk_last;
      stat.wake_ok = s_rec_ff.receiving &&
                     ((s_rec_ff.src == me_p) || (s_rec_ff.src == CODE_ANY));
      stat.head_empty = s_rec_ff.head >= CODE_NONE;
      stat.tail_here = rd_q.q_next >= CODE_NONE;
      stat.pend_take = me_rec_ff.pend &&
                       ((kind_ff == rie_pkg::KIND_ANY) || (kind_ff == rie_pkg::KIND_INTR));
      stat.me_head_empty = me_rec_ff.head >= CODE_NONE;
      stat.s_ok = rd_q.sending && (rd_q.target == me_p);
      stat.ul_miss = (cur_ff >= CODE_NONE) || (steps_ff == SW'(NUM_PROCS));
      stat.ul_hit = cur_ff == s_ff;
      stat.prev_none = prev_ff >= CODE_NONE;
      stat.notice_wake = me_rec_ff.receiving &&
                         ((me_rec_ff.src == CODE_INTR) || (me_rec_ff.src == CODE_ANY));
      stat.first_step = steps_ff == '0;
      stat.out_free = !out_valid_ff || rsp_tready;
   end

endmodule

// ----- rtl/rie_controller.sv -----
// request sequencer: decode, deadlock walk, queue append and unlink walks
// depends on rie_pkg; commands rie_datapath
module rie_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rie_pkg::status_type stat,
   output rie_pkg::cmd_type    cmd
);
   localparam logic [4:0] IDLE    = 5'd0;
   localparam logic [4:0] LD_ME   = 5'd1;
   localparam logic [4:0] ME_LD   = 5'd2;
   localparam logic [4:0] CHK     = 5'd3;
   localparam logic [4:0] DL_RD   = 5'd4;
   localparam logic [4:0] DL_EV   = 5'd5;
   localparam logic [4:0] SND_DEC = 5'd6;
   localparam logic [4:0] ENQ     = 5'd7;
   localparam logic [4:0] EQ_RD   = 5'd8;
   localparam logic [4:0] EQ_EV   = 5'd9;
   localparam logic [4:0] RS_RD   = 5'd10;
   localparam logic [4:0] RS_EV   = 5'd11;
   localparam logic [4:0] UL_TST  = 5'd12;
   localparam logic [4:0] UL_RD   = 5'd13;
   localparam logic [4:0] UL_EV   = 5'd14;
   localparam logic [4:0] UL_FIX  = 5'd15;
   localparam logic [4:0] UL_REL  = 5'd16;
   localparam logic [4:0] RCV_BLK = 5'd17;
   localparam logic [4:0] FIN     = 5'd18;

   logic [4:0] state_ff, state_in;

   assign req_tready = state_ff == IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = rie_pkg::RD_CUR;
      unique case (state_ff)
         IDLE: begin
            cmd.ld_req = req_tvalid;
            if (req_tvalid) state_in = LD_ME;
         end
         LD_ME: begin
            cmd.rd_sel = rie_pkg::RD_ME;
            state_in = ME_LD;
         end
         ME_LD: begin
            cmd.ld_me = 1'b1;
            state_in = CHK;
         end
         CHK: begin
            state_in = FIN;
            if (stat.me_bad) begin
               cmd.res_op = rie_pkg::RES_BAD;
            end else if (stat.func == rie_pkg::FUNC_SEND) begin
               cmd.s_op = rie_pkg::S_PEER;
               cmd.cur_op = rie_pkg::CUR_PEER;
               state_in = DL_RD;
            end else if (stat.func == rie_pkg::FUNC_RECV) begin
               if (stat.pend_take) begin
                  cmd.wr_op = rie_pkg::WR_ME_INT_CLR;
                  cmd.res_op = rie_pkg::RES_INT_TAKE;
               end else if (stat.kind == rie_pkg::KIND_INTR) begin
                  state_in = RCV_BLK;
               end else if (stat.kind == rie_pkg::KIND_ANY) begin
                  if (stat.me_head_empty) begin
                     state_in = RCV_BLK;
                  end else begin
                     cmd.s_op = rie_pkg::S_ME_HEAD;
                     state_in = RS_RD;
                  end
               end else begin
                  cmd.s_op = rie_pkg::S_PEER;
                  state_in = RS_RD;
               end
            end else if (stat.notice_wake) begin
               cmd.wr_op = rie_pkg::WR_ME_NTC_WAKE;
               cmd.res_op = rie_pkg::RES_NTC_WAKE;
            end else begin
               cmd.wr_op = rie_pkg::WR_ME_PEND_SET;
               cmd.res_op = rie_pkg::RES_NTC_PEND;
            end
         end
         DL_RD: state_in = DL_EV;
         DL_EV: begin
            // first entry of the chain is the destination, kept for later
            cmd.ld_s = stat.first_step;
            if (stat.dl_hit) begin
               cmd.res_op = rie_pkg::RES_DL;
               state_in = FIN;
            end else if (stat.dl_stop) begin
               state_in = SND_DEC;
            end else begin
               cmd.cur_op = rie_pkg::CUR_TGT;
               state_in = DL_RD;
            end
         end
         SND_DEC: begin
            if (stat.wake_ok) begin
               cmd.wr_op = rie_pkg::WR_RCV_REL_S;
               cmd.res_op = rie_pkg::RES_SEND_WAKE;
               state_in = FIN;
            end else begin
               cmd.wr_op = rie_pkg::WR_ME_SEND_BLK;
               cmd.res_op = rie_pkg::RES_SEND_BLK;
               state_in = ENQ;
            end
         end
         ENQ: begin
            if (stat.head_empty) begin
               cmd.wr_op = rie_pkg::WR_HEAD_S;
               state_in = FIN;
            end else begin
               cmd.cur_op = rie_pkg::CUR_S_HEAD;
               state_in = EQ_RD;
            end
         end
         EQ_RD: state_in = EQ_EV;
         EQ_EV: begin
            if (stat.tail_here) begin
               cmd.wr_op = rie_pkg::WR_TAIL;
               state_in = FIN;
            end else if (stat.walk_last) begin
               state_in = FIN;
            end else begin
               cmd.cur_op = rie_pkg::CUR_QNEXT;
               state_in = EQ_RD;
            end
         end
         RS_RD: begin
            cmd.rd_sel = rie_pkg::RD_S;
            state_in = RS_EV;
         end
         RS_EV: begin
            cmd.ld_s = 1'b1;
            if (stat.kind == rie_pkg::KIND_SPEC && !stat.s_ok) begin
               state_in = RCV_BLK;
            end else begin
               cmd.cur_op = rie_pkg::CUR_ME_HEAD;
               state_in = UL_TST;
            end
         end
         UL_TST: begin
            priority if (stat.ul_miss) begin
               state_in = RCV_BLK;
            end else if (stat.ul_hit) begin
               state_in = UL_FIX;
            end else begin
               state_in = UL_RD;
            end
         end
         UL_RD: state_in = UL_EV;
         UL_EV: begin
            cmd.cur_op = rie_pkg::CUR_QNEXT;
            state_in = UL_TST;
         end
         UL_FIX: begin
            cmd.wr_op = stat.prev_none ? rie_pkg::WR_ME_HEAD : rie_pkg::WR_PREV_NEXT;
            cmd.res_op = rie_pkg::RES_RECV_WAKE;
            state_in = UL_REL;
         end
         UL_REL: begin
            cmd.wr_op = rie_pkg::WR_S_REL_SND;
            state_in = FIN;
         end
         RCV_BLK: begin
            cmd.wr_op = rie_pkg::WR_ME_RCV_BLK;
            cmd.res_op = rie_pkg::RES_RECV_BLK;
            state_in = FIN;
         end
         FIN: begin
            cmd.push = stat.out_free;
            if (stat.out_free) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

endmodule

// ----- rtl/rendezvous_ipc_engine_core.sv -----
// Rendezvous IPC engine: one request word in, one result word out. A request
// that is invalid, a notice and a receive that takes a pending interrupt are
// settled without a walk of the table, as is a receive that blocks at once on
// an interrupt or an empty queue. A receive that names a peer or takes the
// head of its queue searches the caller's sender queue, through UL_TST, UL_RD
// and UL_EV for each entry. A send walks the chain of waiting senders for a
// deadlock (DL_RD, DL_EV) and then the destination's queue to append itself
// (EQ_RD, EQ_EV), on the single read port of the rendezvous table. The block
// takes one request at a time; a finished result waits in an output register,
// so the next request can be taken before that result is drained.
// Depends on rie_pkg, rie_controller and rie_datapath.
module rendezvous_ipc_engine_core #(
   parameter int NUM_PROCS = 16,
   parameter int ADDR_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // proc_id[3:0], peer_pid[7:4], msg_addr, zero fill
   input  logic [((8+ADDR_BITS+7)/8)*8-1:0]    req_tdata,
   // func[1:0], peer_kind[3:2]
   input  logic [3:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // woken_pid, copy_dst_pid, copy_dst_addr, copy_src_pid, copy_src_addr, zero fill
   output logic [((12+2*ADDR_BITS+7)/8)*8-1:0] rsp_tdata,
   // status[1:0], caller_blocked[2], woken_valid[3], copy_kind[5:4]
   output logic [5:0] rsp_tuser
);
   rie_pkg::cmd_type    cmd;
   rie_pkg::status_type stat;

   rie_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rie_datapath #(
      .NUM_PROCS (NUM_PROCS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/rie_checker.sv -----
// port-level checks of the rendezvous ipc engine, bound to the top level
// depends on rie_pkg and rendezvous_ipc_engine_core_defines.svh
`include "rendezvous_ipc_engine_core_defines.svh"

module rie_checker #(
   parameter int ADDR_BITS = 32
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [((8+ADDR_BITS+7)/8)*8-1:0]    req_tdata,
   input logic [3:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((12+2*ADDR_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic [5:0] rsp_tuser
);
   localparam int RSP_DW = ((12+2*ADDR_BITS+7)/8)*8;

   `RIE_ASSERT_IMPLY(a_invalid_clean, clock, reset,
      rsp_tvalid && rsp_tuser[1:0] == rie_pkg::ST_INVALID,
      rsp_tuser[5:2] == 4'd0 && rsp_tdata == '0, "invalid result carries data")
   `RIE_ASSERT_IMPLY(a_woken_pid_zero, clock, reset, rsp_tvalid && !rsp_tuser[3],
      rsp_tdata[3:0] == 4'd0, "woken pid set without wake")
   `RIE_ASSERT_IMPLY(a_copy_zero, clock, reset,
      rsp_tvalid && rsp_tuser[5:4] == rie_pkg::CP_NONE,
      rsp_tdata[RSP_DW-1:4] == '0, "copy fields set without copy")
   `RIE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready,
      !req_tready, "request taken while one is in work")
   `RIE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind rendezvous_ipc_engine_core rie_checker #(.ADDR_BITS(ADDR_BITS)) u_rie_checker (.*);

// ----- verif/tb.sv -----
// self-checking testbench for rendezvous_ipc_engine_core: directed table, then random traffic
// keeps its own rendezvous table to predict every result word; depends on rie_pkg and the rtl
module tb;

   localparam int NPROC  = 16;
   localparam int P_NONE = NPROC;
   localparam int P_ANY  = NPROC + 1;
   localparam int P_INTR = NPROC + 2;
   localparam int N_RANDOM = 1430;

   typedef struct {
      logic [1:0]  func;
      logic [3:0]  me;
      logic [1:0]  kind;
      logic [3:0]  peer;
      logic [31:0] addr;
   } call_type;

   typedef struct {
      logic [1:0]  status;
      logic        blocked;
      logic        wvalid;
      logic [3:0]  wpid;
      logic [1:0]  ckind;
      logic [3:0]  dpid;
      logic [31:0] daddr;
      logic [3:0]  spid;
      logic [31:0] saddr;
   } outcome_type;

   typedef struct {
      call_type    c;
      bit          typed;
      outcome_type o;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [5:0]  rsp_tuser;

   rendezvous_ipc_engine_core u_dut (.*);

   always #6 clock = ~clock;

   // predictor copy of the rendezvous table
   bit          snd_flag [NPROC];
   bit          rcv_flag [NPROC];
   int          snd_tgt  [NPROC];
   int          rcv_src  [NPROC];
   logic [31:0] buf_addr [NPROC];
   bit          pend     [NPROC];
   int          q_head   [NPROC];
   int          q_next   [NPROC];

   outcome_type expected_words[$];
   int          n_fail = 0;
   int          n_words = 0;

   function automatic bit chain_closes(int from, int to);
      int cur;
      cur = to;
      for (int i = 0; i < NPROC; i++) begin
         if (cur >= NPROC || !snd_flag[cur]) return 0;
         if (snd_tgt[cur] == from) return 1;
         cur = snd_tgt[cur];
      end
      return 0;
   endfunction

   function automatic void queue_append(int rcv, int snd);
      int cur;
      cur = q_head[rcv];
      q_next[snd] = P_NONE;
      if (cur >= NPROC) begin
         q_head[rcv] = snd;
         return;
      end
      for (int i = 0; i < NPROC; i++) begin
         if (q_next[cur] >= NPROC) begin
            q_next[cur] = snd;
            return;
         end
         cur = q_next[cur];
      end
   endfunction

   function automatic bit queue_unlink(int rcv, int snd);
      int cur, prev;
      cur = q_head[rcv];
      prev = P_NONE;
      for (int i = 0; i < NPROC && cur < NPROC; i++) begin
         if (cur == snd) begin
            if (prev >= NPROC) q_head[rcv] = q_next[cur];
            else q_next[prev] = q_next[cur];
            q_next[cur] = P_NONE;
            return 1;
         end
         prev = cur;
         cur = q_next[cur];
      end
      return 0;
   endfunction

   function automatic outcome_type rendezvous_step(call_type c);
      outcome_type o;
      int me, pr, from, h;
      bit bad;
      o = '{default: '0};
      me = int'(c.me);
      pr = int'(c.peer);
      from = P_NONE;
      bad = (c.func == rie_pkg::FUNC_BAD);
      if (!bad && c.func != rie_pkg::FUNC_NOTICE) begin
         if (c.kind == rie_pkg::KIND_BAD || (c.kind == rie_pkg::KIND_SPEC && pr == me)) bad = 1;
         if (c.func == rie_pkg::FUNC_SEND && c.kind != rie_pkg::KIND_SPEC) bad = 1;
         if (snd_flag[me] || rcv_flag[me]) bad = 1;
      end
      if (bad) begin
         o.status = rie_pkg::ST_INVALID;
         return o;
      end
      o.status = rie_pkg::ST_OK;
      if (c.func == rie_pkg::FUNC_SEND) begin
         if (chain_closes(me, pr)) begin
            o.status = rie_pkg::ST_DEADLOCK;
         end else if (rcv_flag[pr] && (rcv_src[pr] == me || rcv_src[pr] == P_ANY)) begin
            o.wvalid = 1; o.wpid = 4'(pr); o.ckind = rie_pkg::CP_SENDER;
            o.dpid = 4'(pr); o.daddr = buf_addr[pr]; o.spid = 4'(me); o.saddr = c.addr;
            rcv_flag[pr] = 0; rcv_src[pr] = P_NONE; buf_addr[pr] = '0;
         end else begin
            snd_flag[me] = 1; snd_tgt[me] = pr; buf_addr[me] = c.addr;
            queue_append(pr, me);
            o.blocked = 1;
         end
      end else if (c.func == rie_pkg::FUNC_RECV) begin
         if (pend[me] && (c.kind == rie_pkg::KIND_ANY || c.kind == rie_pkg::KIND_INTR)) begin
            pend[me] = 0;
            o.ckind = rie_pkg::CP_INTR; o.dpid = 4'(me); o.daddr = c.addr;
            return o;
         end
         if (c.kind == rie_pkg::KIND_ANY) begin
            h = q_head[me];
            if (h < NPROC && queue_unlink(me, h)) from = h;
         end else if (c.kind == rie_pkg::KIND_SPEC) begin
            if (snd_flag[pr] && snd_tgt[pr] == me && queue_unlink(me, pr)) from = pr;
         end
         if (from < NPROC) begin
            o.wvalid = 1; o.wpid = 4'(from); o.ckind = rie_pkg::CP_SENDER;
            o.dpid = 4'(me); o.daddr = c.addr; o.spid = 4'(from); o.saddr = buf_addr[from];
            snd_flag[from] = 0; snd_tgt[from] = P_NONE; buf_addr[from] = '0;
            q_next[from] = P_NONE;
         end else begin
            rcv_flag[me] = 1; buf_addr[me] = c.addr;
            rcv_src[me] = (c.kind == rie_pkg::KIND_ANY) ? P_ANY :
                          (c.kind == rie_pkg::KIND_INTR) ? P_INTR : pr;
            o.blocked = 1;
         end
      end else begin
         if (rcv_flag[me] && (rcv_src[me] == P_INTR || rcv_src[me] == P_ANY)) begin
            o.wvalid = 1; o.wpid = 4'(me); o.ckind = rie_pkg::CP_INTR;
            o.dpid = 4'(me); o.daddr = buf_addr[me];
            rcv_flag[me] = 0; rcv_src[me] = P_NONE; buf_addr[me] = '0;
            pend[me] = 0;
         end else begin
            pend[me] = 1;
         end
      end
      return o;
   endfunction

   function automatic call_type random_call(int pool);
      call_type c;
      int sel;
      c.addr = $urandom;
      c.me = 4'($urandom_range(0, pool - 1));
      for (int t = 0; t < 8 && (snd_flag[c.me] || rcv_flag[c.me]); t++)
         if ($urandom_range(0, 9) != 0) c.me = 4'($urandom_range(0, pool - 1));
      c.peer = 4'($urandom_range(0, pool - 1));
      if (c.peer == c.me && $urandom_range(0, 19) != 0) c.peer = 4'((int'(c.me) + 1) % pool);
      sel = int'($urandom_range(0, 99));
      if (sel < 42) begin
         c.func = rie_pkg::FUNC_SEND; c.kind = rie_pkg::KIND_SPEC;
      end else if (sel < 82) begin
         c.func = rie_pkg::FUNC_RECV;
         sel = int'($urandom_range(0, 9));
         c.kind = (sel < 4) ? rie_pkg::KIND_SPEC : (sel < 8) ? rie_pkg::KIND_ANY :
                  rie_pkg::KIND_INTR;
      end else if (sel < 94) begin
         c.func = rie_pkg::FUNC_NOTICE; c.kind = 2'($urandom_range(0, 3));
         c.peer = 4'($urandom_range(0, 15));
      end else begin
         c.func = 2'($urandom_range(0, 3)); c.kind = 2'($urandom_range(0, 3));
         c.me = 4'($urandom_range(0, 15)); c.peer = 4'($urandom_range(0, 15));
      end
      return c;
   endfunction

   // sender: bursts with random gaps, one word held until taken
   int burst_left = 0;

   task automatic offer_call(call_type c, bit typed, outcome_type o_typed);
      outcome_type o;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = {c.addr, c.peer, c.me};
      req_tuser  = {c.kind, c.func};
      do @(posedge clock); while (!req_tready);
      o = rendezvous_step(c);
      expected_words.push_back(typed ? o_typed : o);
      @(negedge clock);
   endtask

   row_type dir_rows[$];

   function automatic row_type mk(logic [1:0] f, int me, logic [1:0] k, int p,
                                  logic [31:0] a, bit typed = 0,
                                  logic [1:0] st = rie_pkg::ST_OK, bit blk = 0);
      row_type r;
      r.c = '{func: f, me: 4'(me), kind: k, peer: 4'(p), addr: a};
      r.typed = typed;
      r.o = '{default: '0};
      r.o.status = st;
      r.o.blocked = blk;
      return r;
   endfunction

   initial begin
      outcome_type none_o;
      none_o = '{default: '0};
      for (int i = 0; i < NPROC; i++) begin
         snd_flag[i] = 0; rcv_flag[i] = 0; snd_tgt[i] = P_NONE; rcv_src[i] = P_NONE;
         buf_addr[i] = '0; pend[i] = 0; q_head[i] = P_NONE; q_next[i] = P_NONE;
      end
      dir_rows = '{
         mk(rie_pkg::FUNC_BAD, 0, rie_pkg::KIND_SPEC, 1, 32'h0, 1, rie_pkg::ST_INVALID),
         mk(rie_pkg::FUNC_RECV, 0, rie_pkg::KIND_BAD, 1, 32'h1234, 1, rie_pkg::ST_INVALID),
         mk(rie_pkg::FUNC_SEND, 1, rie_pkg::KIND_SPEC, 1, 32'h5, 1, rie_pkg::ST_INVALID),
         mk(rie_pkg::FUNC_SEND, 1, rie_pkg::KIND_ANY, 2, 32'h5, 1, rie_pkg::ST_INVALID),
         mk(rie_pkg::FUNC_RECV, 0, rie_pkg::KIND_INTR, 3, 32'h0, 1, rie_pkg::ST_OK, 1),
         mk(rie_pkg::FUNC_RECV, 0, rie_pkg::KIND_ANY, 3, 32'h10, 1, rie_pkg::ST_INVALID),
         mk(rie_pkg::FUNC_NOTICE, 0, rie_pkg::KIND_BAD, 15, 32'hffff_ffff),
         mk(rie_pkg::FUNC_NOTICE, 2, rie_pkg::KIND_SPEC, 0, 32'h0, 1, rie_pkg::ST_OK, 0),
         mk(rie_pkg::FUNC_NOTICE, 2, rie_pkg::KIND_SPEC, 0, 32'h0, 1, rie_pkg::ST_OK, 0),
         mk(rie_pkg::FUNC_RECV, 2, rie_pkg::KIND_ANY, 0, 32'hffff_ffff),
         mk(rie_pkg::FUNC_SEND, 3, rie_pkg::KIND_SPEC, 4, 32'hffff_ffff, 1, rie_pkg::ST_OK, 1),
         mk(rie_pkg::FUNC_SEND, 4, rie_pkg::KIND_SPEC, 5, 32'h8000_0001, 1, rie_pkg::ST_OK, 1),
         mk(rie_pkg::FUNC_SEND, 5, rie_pkg::KIND_SPEC, 3, 32'h1, 1, rie_pkg::ST_DEADLOCK),
         mk(rie_pkg::FUNC_RECV, 4, rie_pkg::KIND_SPEC, 3, 32'h4444),
         mk(rie_pkg::FUNC_SEND, 6, rie_pkg::KIND_SPEC, 4, 32'h6666),
         mk(rie_pkg::FUNC_RECV, 5, rie_pkg::KIND_ANY, 0, 32'h5555),
         mk(rie_pkg::FUNC_RECV, 4, rie_pkg::KIND_SPEC, 6, 32'h4000),
         mk(rie_pkg::FUNC_RECV, 7, rie_pkg::KIND_SPEC, 8, 32'h7777, 1, rie_pkg::ST_OK, 1),
         mk(rie_pkg::FUNC_SEND, 8, rie_pkg::KIND_SPEC, 7, 32'h8888),
         mk(rie_pkg::FUNC_SEND, 15, rie_pkg::KIND_SPEC, 0, 32'h0),
         mk(rie_pkg::FUNC_SEND, 14, rie_pkg::KIND_SPEC, 0, 32'hdead_beef),
         mk(rie_pkg::FUNC_RECV, 0, rie_pkg::KIND_SPEC, 14, 32'h100),
         mk(rie_pkg::FUNC_RECV, 0, rie_pkg::KIND_ANY, 14, 32'h200),
         mk(rie_pkg::FUNC_RECV, 9, rie_pkg::KIND_SPEC, 10, 32'h900, 1, rie_pkg::ST_OK, 1),
         mk(rie_pkg::FUNC_NOTICE, 9, rie_pkg::KIND_SPEC, 0, 32'h0)
      };
      repeat (3) @(negedge clock);
      reset = 1'b0;
      foreach (dir_rows[i]) offer_call(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].o);
      for (int n = 0; n < N_RANDOM; n++)
         offer_call(random_call((n % 200 < 150) ? 4 : 16), 0, none_o);
      req_tvalid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (n_fail == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // receiver: stretches of full speed and random stalls, plus one long hold-off
   initial begin
      bit long_done;
      int mode;
      long_done = 0;
      mode = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_done && n_words >= 300) begin
            long_done = 1;
            rsp_tready = 1'b0;
            for (int i = 0; i < 400; i++) @(negedge clock);
         end
         mode = int'($urandom_range(0, 2));
         for (int i = 0; i < 48; i++) begin
            rsp_tready = (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
            @(negedge clock);
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_words++;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            n_fail++;
         end else begin
            e = expected_words.pop_front();
            check_field("status", 32'(e.status), 32'(rsp_tuser[1:0]));
            check_field("caller_blocked", 32'(e.blocked), 32'(rsp_tuser[2]));
            check_field("woken_valid", 32'(e.wvalid), 32'(rsp_tuser[3]));
            check_field("copy_kind", 32'(e.ckind), 32'(rsp_tuser[5:4]));
            check_field("woken_pid", 32'(e.wpid), 32'(rsp_tdata[3:0]));
            check_field("copy_dst_pid", 32'(e.dpid), 32'(rsp_tdata[7:4]));
            check_field("copy_dst_addr", e.daddr, rsp_tdata[39:8]);
            check_field("copy_src_pid", 32'(e.spid), 32'(rsp_tdata[43:40]));
            check_field("copy_src_addr", e.saddr, rsp_tdata[75:44]);
            check_field("zero_fill", 32'h0, 32'(rsp_tdata[79:76]));
         end
      end
   end

   initial begin
      #30_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
